// File: rtl/dsgr_pkg.sv
// dsgr_pkg: shared types and constants for the drag stroke gesture recognizer
// used by dsgr_classify, dsgr_track and the top level; no dependencies

package dsgr_pkg;

    localparam int OFS_W           = 16;
    localparam int THR_W           = 8;
    localparam int REQ_W           = 2;
    localparam int ACT_W           = 3;
    localparam int MAX_STROKES_DEF = 2;
    localparam logic [THR_W-1:0] THR_RESET = 8'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_UPDATE = 2'd0,
        REQ_END    = 2'd1,
        REQ_CANCEL = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_UP    = 3'd4
    } dir_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_BACK    = 3'd1,
        ACT_FORWARD = 3'd2,
        ACT_NEWTAB  = 3'd3,
        ACT_CLOSE   = 3'd4,
        ACT_RELOAD  = 3'd5
    } act_t;

    typedef struct packed {
        logic [REQ_W-1:0]        req;
        logic signed [OFS_W-1:0] x;
        logic signed [OFS_W-1:0] y;
    } item_t;

    // classification of one update against the stored offset
    typedef struct packed {
        dir_t dir;
        logic over_thr;
    } step_t;

    typedef struct packed {
        act_t action;
        logic claimed;
    } res_t;

endpackage

// File: rtl/dsgr_classify.sv
// dsgr_classify: step delta direction and threshold test for one update
// combinational; depends on dsgr_pkg

module dsgr_classify
    import dsgr_pkg::*;
(
    input  logic signed [OFS_W-1:0] x,
    input  logic signed [OFS_W-1:0] y,
    input  logic signed [OFS_W-1:0] prev_x,
    input  logic signed [OFS_W-1:0] prev_y,
    input  logic [THR_W-1:0]        threshold,
    output step_t                   step
);

    logic signed [OFS_W:0] dx;
    logic signed [OFS_W:0] dy;
    logic [OFS_W:0]        dx_neg;
    logic [OFS_W:0]        dy_neg;
    logic [OFS_W-1:0]      ax;
    logic [OFS_W-1:0]      ay;
    logic [OFS_W-1:0]      mx;
    logic [OFS_W-1:0]      my;
    logic [OFS_W-1:0]      x_neg;
    logic [OFS_W-1:0]      y_neg;

    always_comb
    begin
        dx     = {x[OFS_W-1], x} - {prev_x[OFS_W-1], prev_x};
        dy     = {y[OFS_W-1], y} - {prev_y[OFS_W-1], prev_y};
        dx_neg = -dx;
        dy_neg = -dy;
        // step magnitude never exceeds 65535, so the sign bit drops out
        ax     = dx[OFS_W] ? dx_neg[OFS_W-1:0] : dx[OFS_W-1:0];
        ay     = dy[OFS_W] ? dy_neg[OFS_W-1:0] : dy[OFS_W-1:0];
        x_neg  = -x;
        y_neg  = -y;
        // most negative offset wraps to 32768, which is its true magnitude
        mx     = x[OFS_W-1] ? x_neg : x;
        my     = y[OFS_W-1] ? y_neg : y;

        step.over_thr = (mx > {{(OFS_W-THR_W){1'b0}}, threshold})
                     || (my > {{(OFS_W-THR_W){1'b0}}, threshold});

        if ({1'b0, ax} > {ay, 1'b0})
        begin
            step.dir = dx[OFS_W] ? DIR_LEFT : DIR_RIGHT;
        end
        else if ({1'b0, ay} > {ax, 1'b0})
        begin
            step.dir = dy[OFS_W] ? DIR_UP : DIR_DOWN;
        end
        else
        begin
            step.dir = DIR_NONE;
        end
    end

endmodule

// File: rtl/dsgr_track.sv
// dsgr_track: gesture state, stroke record and action lookup
// depends on dsgr_pkg and dsgr_classify

module dsgr_track
    import dsgr_pkg::*;
#(
    parameter int MAX_STROKES = MAX_STROKES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    input  logic [THR_W-1:0] threshold,
    output res_t             res
);

    localparam int CNT_W = $clog2(MAX_STROKES + 1);
    localparam int IDX_W = $clog2(MAX_STROKES);

    logic signed [OFS_W-1:0] prev_x_reg, prev_x_next;
    logic signed [OFS_W-1:0] prev_y_reg, prev_y_next;
    logic                    active_reg, active_next;
    dir_t                    cur_dir_reg, cur_dir_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    dir_t                    dirs_reg [MAX_STROKES];
    logic                    rec;
    logic                    act_upd;
    step_t                   step;

    dsgr_classify u_classify (
        .x         (item.x),
        .y         (item.y),
        .prev_x    (prev_x_reg),
        .prev_y    (prev_y_reg),
        .threshold (threshold),
        .step      (step)
    );

    // action from the recorded run
    always_comb
    begin
        res.action  = ACT_NONE;
        res.claimed = active_reg;
        if (active_reg && count_reg == CNT_W'(1))
        begin
            case (dirs_reg[0])
                DIR_LEFT:  res.action = ACT_BACK;
                DIR_RIGHT: res.action = ACT_FORWARD;
                DIR_DOWN:  res.action = ACT_NEWTAB;
                default:   res.action = ACT_NONE;
            endcase
        end
        else if (active_reg && count_reg == CNT_W'(2))
        begin
            if (dirs_reg[0] == DIR_DOWN && dirs_reg[1] == DIR_RIGHT)
            begin
                res.action = ACT_CLOSE;
            end
            else if (dirs_reg[0] == DIR_UP && dirs_reg[1] == DIR_DOWN)
            begin
                res.action = ACT_RELOAD;
            end
        end
    end

    always_comb
    begin
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        active_next  = active_reg;
        cur_dir_next = cur_dir_reg;
        count_next   = count_reg;
        act_upd      = active_reg | step.over_thr;
        rec          = 1'b0;
        if (fire)
        begin
            case (req_t'(item.req))
                REQ_UPDATE:
                begin
                    prev_x_next = item.x;
                    prev_y_next = item.y;
                    active_next = act_upd;
                    if (act_upd && count_reg < CNT_W'(MAX_STROKES)
                        && step.dir != DIR_NONE && step.dir != cur_dir_reg)
                    begin
                        rec          = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        cur_dir_next = step.dir;
                    end
                end
                REQ_END, REQ_CANCEL:
                begin
                    // end while inactive leaves everything as it is
                    if (req_t'(item.req) == REQ_CANCEL || active_reg)
                    begin
                        prev_x_next  = '0;
                        prev_y_next  = '0;
                        active_next  = 1'b0;
                        cur_dir_next = DIR_NONE;
                        count_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            active_reg  <= 1'b0;
            cur_dir_reg <= DIR_NONE;
            count_reg   <= '0;
        end
        else
        begin
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            active_reg  <= active_next;
            cur_dir_reg <= cur_dir_next;
            count_reg   <= count_next;
        end
    end

    // entries are only read below the stroke count, so no reset
    always_ff @(posedge clk)
    begin
        if (rec)
        begin
            dirs_reg[count_reg[IDX_W-1:0]] <= step.dir;
        end
    end

endmodule

// File: rtl/drag_stroke_gesture_recognizer_core.sv
// drag_stroke_gesture_recognizer_core: top level with input and result registers
// depends on dsgr_pkg, dsgr_track and dsgr_classify
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | tdata: pos_x, pos_y; tuser: req
//  m_axis    | out | m_axis_tvalid/tready   | tdata: action; tuser: claimed
//  cfg       | in  | cfg_we                 | cfg_wdata: drag_threshold
//
// one item per clock while no drag end waits on a full result register; a drag
// end's result is loaded into the result register as the end leaves the input register
// reset clears the gesture state and sets the threshold to 8
// a stalled result register holds back only a drag end; updates and cancels
// keep flowing while a result waits

module drag_stroke_gesture_recognizer_core
    import dsgr_pkg::*;
#(
    parameter int MAX_STROKES = MAX_STROKES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // [15:0] pos_x, [31:16] pos_y
    input  logic [REQ_W-1:0] s_axis_tuser,   // [1:0] req_type
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [2:0] action, [7:3] zero
    output logic             m_axis_tuser,   // [0] claimed
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata
);

    logic [THR_W-1:0] thr_reg;
    logic             in_vld_reg;
    item_t            in_reg;
    logic             out_vld_reg;
    res_t             out_reg;
    res_t             res;
    logic             is_end;
    logic             out_ok;
    logic             proc_fire;
    logic             out_load;

    always_comb
    begin
        is_end        = (req_t'(in_reg.req) == REQ_END);
        out_ok        = !out_vld_reg || m_axis_tready;
        proc_fire     = in_vld_reg && (!is_end || out_ok);
        out_load      = proc_fire && is_end;
        s_axis_tready = !in_vld_reg || proc_fire;
        m_axis_tvalid = out_vld_reg;
        m_axis_tdata  = {5'd0, out_reg.action};
        m_axis_tuser  = out_reg.claimed;
    end

    dsgr_track #(
        .MAX_STROKES (MAX_STROKES)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .item      (in_reg),
        .threshold (thr_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THR_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg.req <= s_axis_tuser;
            in_reg.x   <= s_axis_tdata[15:0];
            in_reg.y   <= s_axis_tdata[31:16];
        end
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    // a drag end that finds the result register blocked stays put
    a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && is_end && !out_ok |=> in_vld_reg && req_t'(in_reg.req) == REQ_END)
        else $error("drag end dropped while result stalled");

    // an unclaimed result never carries an action
    a_unclaimed_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.claimed |-> out_reg.action == ACT_NONE)
        else $error("unclaimed result with an action");

    // input side stalls only behind a drag end waiting on a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_vld_reg && is_end && out_vld_reg && !m_axis_tready)
        else $error("input stalled without cause");

endmodule
